// ===== sv/pos_pkg.sv =====
// Shared types, widths and the run-order compare for the priority order scheduler.
package pos_pkg;

	localparam int ID_W    = 8;
	localparam int PRIO_W  = 8;
	localparam int BURST_W = 16;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [PRIO_W-1:0]  prio;
		logic [BURST_W-1:0] burst;
	} task_ent_t;

	// controller -> datapath
	typedef struct packed {
		logic insert;
		logic drop;
		logic pop;
	} pos_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic last_one;
	} pos_stat_t;

	typedef enum logic [1:0] {
		ST_LOAD = 2'b01,
		ST_EMIT = 2'b10
	} pos_state_t;

	// a strictly ahead of b: higher priority, then lower id
	function automatic logic pos_runs_before(
		input logic [ID_W-1:0]   ida,
		input logic [PRIO_W-1:0] pa,
		input logic [ID_W-1:0]   idb,
		input logic [PRIO_W-1:0] pb
	);
		logic res;
		if (pa != pb) begin
			res = (pa > pb);
		end else begin
			res = (ida < idb);
		end
		return res;
	endfunction

endpackage

// ===== sv/priority_order_scheduler.sv =====
// Top level of the priority order scheduler: batch load, then run-order drain.
//
//  channel | handshake               | payload
//  --------+-------------------------+---------------------------------------------
//  task    | task_valid / task_stall | task_id, task_priority, burst_length, last_task
//  run     | run_valid / run_stall   | run_id, run_priority, run_slice, final_slot,
//          |                         | overflowed
//
// Loading: one request per cycle; each task lands in its sorted cell in that cycle, or is
// dropped and sets overflowed when all cells are full. After the last task, the batch drains
// one result per cycle from the head cell while run_stall is low; task_stall stays high for
// the whole drain (N results, N = stored tasks). run_stall freezes the head cell, so a stalled
// result holds. Reset empties the batch and clears the overflow flag; cells need no clearing.
module priority_order_scheduler #(
	parameter int MAX_TASKS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          task_valid,
	output logic                          task_stall,
	input  logic [pos_pkg::ID_W-1:0]      task_id,
	input  logic [pos_pkg::PRIO_W-1:0]    task_priority,
	input  logic [pos_pkg::BURST_W-1:0]   burst_length,
	input  logic                          last_task,
	output logic                          run_valid,
	input  logic                          run_stall,
	output logic [pos_pkg::ID_W-1:0]      run_id,
	output logic [pos_pkg::PRIO_W-1:0]    run_priority,
	output logic [pos_pkg::BURST_W-1:0]   run_slice,
	output logic                          final_slot,
	output logic                          overflowed
);
	import pos_pkg::*;

	pos_cmd_t  cmd;
	pos_stat_t stat;

	pos_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.task_valid (task_valid),
		.last_task  (last_task),
		.task_stall (task_stall),
		.run_valid  (run_valid),
		.run_stall  (run_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	pos_datapath #(
		.MAX_TASKS (MAX_TASKS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.task_id       (task_id),
		.task_priority (task_priority),
		.burst_length  (burst_length),
		.run_id        (run_id),
		.run_priority  (run_priority),
		.run_slice     (run_slice),
		.final_slot    (final_slot),
		.overflowed    (overflowed)
	);

	// drain and load never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid |-> task_stall)
		else $error("results offered while tasks are accepted");

	// a last task always starts the drain
	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(task_valid && !task_stall && last_task) |=> run_valid)
		else $error("no result after last task");

	// taking the final result ends the drain
	a_final_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(run_valid && !run_stall && final_slot) |=> (!run_valid && !task_stall))
		else $error("drain did not end after final result");

endmodule

// ===== sv/pos_ctrl.sv =====
// Controller for the priority order scheduler: load phase and drain phase.
module pos_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               task_valid,
	input  logic               last_task,
	output logic               task_stall,
	output logic               run_valid,
	input  logic               run_stall,
	input  pos_pkg::pos_stat_t stat,
	output pos_pkg::pos_cmd_t  cmd
);
	import pos_pkg::*;

	pos_state_t state_q;
	pos_state_t state_d;
	logic       acc;

	assign task_stall = (state_q != ST_LOAD);
	assign run_valid  = (state_q == ST_EMIT);
	assign acc        = task_valid && (state_q == ST_LOAD);

	assign cmd.insert = acc && !stat.full;
	assign cmd.drop   = acc && stat.full;
	assign cmd.pop    = run_valid && !run_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (acc && last_task) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (cmd.pop && stat.last_one) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/pos_datapath.sv =====
// Datapath: row of sorted insertion cells, fill count and overflow flag.
module pos_datapath #(
	parameter int MAX_TASKS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pos_pkg::pos_cmd_t             cmd,
	output pos_pkg::pos_stat_t            stat,
	input  logic [pos_pkg::ID_W-1:0]      task_id,
	input  logic [pos_pkg::PRIO_W-1:0]    task_priority,
	input  logic [pos_pkg::BURST_W-1:0]   burst_length,
	output logic [pos_pkg::ID_W-1:0]      run_id,
	output logic [pos_pkg::PRIO_W-1:0]    run_priority,
	output logic [pos_pkg::BURST_W-1:0]   run_slice,
	output logic                          final_slot,
	output logic                          overflowed
);
	import pos_pkg::*;

	localparam int CNT_W = $clog2(MAX_TASKS + 1);

	task_ent_t               ent_q [MAX_TASKS];
	logic [MAX_TASKS-1:0]    ahead;
	logic [CNT_W-1:0]        cnt_q;
	logic                    ovf_q;
	task_ent_t               new_ent;

	assign new_ent.id    = task_id;
	assign new_ent.prio  = task_priority;
	assign new_ent.burst = burst_length;

	assign stat.full     = (cnt_q == CNT_W'(MAX_TASKS));
	assign stat.last_one = (cnt_q == CNT_W'(1));

	// each cell: does the new task go ahead of what it holds (empty cells: yes)
	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		assign ahead[i] = (CNT_W'(i) < cnt_q) ?
			pos_runs_before(task_id, task_priority, ent_q[i].id, ent_q[i].prio) : 1'b1;

		if (i == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (cmd.insert && ahead[i]) begin
					ent_q[i] <= new_ent;
				end else if (cmd.pop) begin
					ent_q[i] <= ent_q[i+1];
				end
			end
		end else if (i == MAX_TASKS - 1) begin : g_tail
			always_ff @(posedge clk) begin
				if (cmd.insert && ahead[i]) begin
					ent_q[i] <= ahead[i-1] ? ent_q[i-1] : new_ent;
				end
			end
		end else begin : g_mid
			always_ff @(posedge clk) begin
				if (cmd.insert && ahead[i]) begin
					ent_q[i] <= ahead[i-1] ? ent_q[i-1] : new_ent;
				end else if (cmd.pop) begin
					ent_q[i] <= ent_q[i+1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (cmd.insert) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.pop) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.drop) begin
				ovf_q <= 1'b1;
			end else if (cmd.pop && stat.last_one) begin
				ovf_q <= 1'b0;
			end
		end
	end

	assign run_id       = ent_q[0].id;
	assign run_priority = ent_q[0].prio;
	assign run_slice    = ent_q[0].burst;
	assign final_slot   = stat.last_one;
	assign overflowed   = ovf_q;

endmodule
